@@ src/tlg_pkg.sv @@
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types and constants of the toroidal Life generation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tlg_pkg;

  localparam int ACT_W   = 2;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NB_W    = 4;

  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;
  localparam int               GRID_SIZE_MIN   = 3;

  localparam logic [NB_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NB_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CELL_DATA,
    ST_ADV_PRE1,
    ST_ADV_PRE2,
    ST_ADV_ROW
  } ctrl_state_t;

  typedef enum logic [2:0] {
    RSEL_CELL,
    RSEL_LAST,
    RSEL_FIRST,
    RSEL_SECOND,
    RSEL_AHEAD
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    load_prev;
    logic    load_cur;
    logic    row_step;
    logic    cell_wr;
    logic    resp;
  } tlg_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_adv;
    logic reject;
    logic last_row;
    logic more_rd;
  } tlg_stat_t;

endpackage

`default_nettype wire

@@ src/tlg_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlg_ctrl
// Sequencer for cell access and row-by-row generation sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module tlg_ctrl
  import tlg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire tlg_stat_t stat_i,
  output tlg_cmd_t       cmd_o
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat_i.reject) state_nxt = ST_IDLE;
        else if (stat_i.is_adv) state_nxt = ST_ADV_PRE1;
        else state_nxt = ST_CELL_DATA;
      end
      ST_CELL_DATA: state_nxt = ST_IDLE;
      ST_ADV_PRE1:  state_nxt = ST_ADV_PRE2;
      ST_ADV_PRE2:  state_nxt = ST_ADV_ROW;
      ST_ADV_ROW: begin
        if (stat_i.last_row) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{capture: 1'b0, rd_en: 1'b0, rd_sel: RSEL_CELL, load_prev: 1'b0,
              load_cur: 1'b0, row_step: 1'b0, cell_wr: 1'b0, resp: 1'b0};
    unique case (state_r)
      ST_IDLE: cmd_o.capture = start;
      ST_DISPATCH: begin
        if (stat_i.reject) begin
          cmd_o.resp = 1'b1;
        end else if (stat_i.is_adv) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RSEL_LAST;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RSEL_CELL;
        end
      end
      ST_CELL_DATA: begin
        cmd_o.cell_wr = stat_i.is_write;
        cmd_o.resp    = 1'b1;
      end
      ST_ADV_PRE1: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = RSEL_FIRST;
        cmd_o.load_prev = 1'b1;
      end
      ST_ADV_PRE2: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RSEL_SECOND;
        cmd_o.load_cur = 1'b1;
      end
      ST_ADV_ROW: begin
        cmd_o.row_step = 1'b1;
        cmd_o.rd_en    = stat_i.more_rd;
        cmd_o.rd_sel   = RSEL_AHEAD;
        cmd_o.resp     = stat_i.last_row;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_DISPATCH))
    else $error("accepted word did not reach dispatch");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.row_step && stat_i.last_row) |=> (state_r == ST_IDLE))
    else $error("generation sweep ran past last row");

  a_resp_place: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.resp |-> (state_r == ST_DISPATCH || state_r == ST_CELL_DATA ||
                    state_r == ST_ADV_ROW))
    else $error("response issued from wrong state");

  a_cell_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.cell_wr |-> $past(cmd_o.rd_en))
    else $error("cell write without preceding row read");

endmodule

`default_nettype wire

@@ src/tlg_dp.sv @@
// ----------------------------------------------------------------------------
// tlg_dp
// Row-wide datapath: grid memory, three-row window, Life rule, result words.
// ----------------------------------------------------------------------------
`default_nettype none

module tlg_dp
  import tlg_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [ACT_W-1:0]     in_action,
  input  wire logic [COORD_W-1:0]   in_col,
  input  wire logic [COORD_W-1:0]   in_row,
  input  wire logic                 in_cell_value,
  output logic                      out_valid,
  output logic                      out_read_value,
  output logic                      out_status,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire tlg_cmd_t             cmd_i,
  output tlg_stat_t                 stat_o
);

  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int RW1  = RW + 1;
  localparam int CIW  = $clog2(MAX_COLS);
  localparam int RIW  = $clog2(MAX_ROWS);
  localparam int SWC  = (CW > CFG_W) ? CW : CFG_W;
  localparam int SWR  = (RW > CFG_W) ? RW : CFG_W;
  localparam int CMPC = (CW > COORD_W) ? CW : COORD_W;
  localparam int CMPR = (RW > COORD_W) ? RW : COORD_W;

  logic [CFG_W-1:0]    grid_width_r, grid_height_r;
  logic [CW-1:0]       eff_w;
  logic [RW-1:0]       eff_h;

  logic [ACT_W-1:0]    act_r;
  logic [COORD_W-1:0]  col_r, row_r;
  logic                val_r;
  logic                coord_bad, reject;

  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid_r;
  logic [MAX_COLS-1:0] mem_q_r, rdata;
  logic                rd_valid_r;
  logic [RIW-1:0]      raddr, waddr;
  logic                we;
  logic [MAX_COLS-1:0] wdata;

  logic [MAX_COLS-1:0] prev_r, cur_r, first_r, dn_row, life_row, cell_row;
  logic [RIW-1:0]      row_cnt_r;
  logic                last_row;

  logic                out_valid_r, out_read_value_r, out_status_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_SIZE_RESET;
      grid_height_r <= GRID_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (SWC'(grid_width_r) < SWC'(GRID_SIZE_MIN)) eff_w = CW'(GRID_SIZE_MIN);
    else if (SWC'(grid_width_r) > SWC'(MAX_COLS)) eff_w = CW'(MAX_COLS);
    else eff_w = CW'(grid_width_r);
    if (SWR'(grid_height_r) < SWR'(GRID_SIZE_MIN)) eff_h = RW'(GRID_SIZE_MIN);
    else if (SWR'(grid_height_r) > SWR'(MAX_ROWS)) eff_h = RW'(MAX_ROWS);
    else eff_h = RW'(grid_height_r);
  end

  // hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      act_r <= in_action;
      col_r <= in_col;
      row_r <= in_row;
      val_r <= in_cell_value;
    end
  end

  assign coord_bad = (CMPC'(col_r) >= CMPC'(eff_w)) || (CMPR'(row_r) >= CMPR'(eff_h));

  always_comb begin
    case (act_r)
      ACT_WRITE, ACT_READ: reject = coord_bad;
      ACT_ADVANCE:         reject = 1'b0;
      default:             reject = 1'b1;
    endcase
  end

  assign last_row = ((RW'(row_cnt_r) + RW'(1)) == eff_h);

  assign stat_o.is_write = (act_r == ACT_WRITE);
  assign stat_o.is_adv   = (act_r == ACT_ADVANCE);
  assign stat_o.reject   = reject;
  assign stat_o.last_row = last_row;
  assign stat_o.more_rd  = ((RW1'(row_cnt_r) + RW1'(2)) < RW1'(eff_h));

  // grid memory, one row per word
  always_comb begin
    unique case (cmd_i.rd_sel)
      RSEL_CELL:   raddr = RIW'(row_r);
      RSEL_LAST:   raddr = RIW'(eff_h - RW'(1));
      RSEL_FIRST:  raddr = '0;
      RSEL_SECOND: raddr = RIW'(1);
      RSEL_AHEAD:  raddr = RIW'(RW1'(row_cnt_r) + RW1'(2));
      default:     raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rd_en) begin
      mem_q_r    <= grid_mem[raddr];
      rd_valid_r <= row_valid_r[raddr];
    end
    if (we) begin
      grid_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (we) begin
      row_valid_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rd_valid_r ? mem_q_r : '0;

  always_comb begin
    cell_row = rdata;
    cell_row[CIW'(col_r)] = val_r;
  end

  assign we    = cmd_i.cell_wr || cmd_i.row_step;
  assign waddr = cmd_i.cell_wr ? RIW'(row_r) : row_cnt_r;
  assign wdata = cmd_i.cell_wr ? cell_row : life_row;

  // three-row window
  assign dn_row = last_row ? first_r : rdata;

  always_ff @(posedge clk) begin
    if (cmd_i.load_prev) begin
      prev_r <= rdata;
    end
    if (cmd_i.load_cur) begin
      cur_r     <= rdata;
      first_r   <= rdata;
      row_cnt_r <= '0;
    end
    if (cmd_i.row_step) begin
      prev_r    <= cur_r;
      cur_r     <= dn_row;
      row_cnt_r <= row_cnt_r + RIW'(1);
    end
  end

  function automatic logic [MAX_COLS-1:0] wrap_left(input logic [MAX_COLS-1:0] x,
                                                    input logic [CW-1:0] w);
    logic [MAX_COLS-1:0] y;
    y = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      if (c == 0) y[c] = x[CIW'(w - CW'(1))];
      else        y[c] = x[c-1];
    end
    return y;
  endfunction

  function automatic logic [MAX_COLS-1:0] wrap_right(input logic [MAX_COLS-1:0] x,
                                                     input logic [CW-1:0] w);
    logic [MAX_COLS-1:0] y;
    y = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      if (CW'(c + 1) == w) y[c] = x[0];
      else                 y[c] = x[(c + 1) % MAX_COLS];
    end
    return y;
  endfunction

  always_comb begin
    logic [MAX_COLS-1:0] ul, ur, ml, mr, dl, dr;
    logic [NB_W-1:0]     n;
    ul = wrap_left(prev_r, eff_w);
    ur = wrap_right(prev_r, eff_w);
    ml = wrap_left(cur_r, eff_w);
    mr = wrap_right(cur_r, eff_w);
    dl = wrap_left(dn_row, eff_w);
    dr = wrap_right(dn_row, eff_w);
    life_row = cur_r;
    for (int c = 0; c < MAX_COLS; c++) begin
      n = NB_W'(ul[c]) + NB_W'(prev_r[c]) + NB_W'(ur[c]) + NB_W'(ml[c]) +
          NB_W'(mr[c]) + NB_W'(dl[c]) + NB_W'(dn_row[c]) + NB_W'(dr[c]);
      if (CW'(c) < eff_w) begin
        life_row[c] = (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && cur_r[c]);
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.resp) begin
      out_status_r     <= reject;
      out_read_value_r <= ((act_r == ACT_READ) && !reject) ? rdata[CIW'(col_r)] : 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  a_out_follows_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd_i.resp))
    else $error("result word without response command");

  a_row_write_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.row_step |-> (RW'(row_cnt_r) < eff_h))
    else $error("sweep writes row outside grid");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.rd_en && we) |-> (raddr != waddr))
    else $error("row read and written in same cycle");

endmodule

`default_nettype wire

@@ src/toroidal_life_generation_top.sv @@
// ----------------------------------------------------------------------------
// toroidal_life_generation_top
// Conway Life (B3/S23) on a configurable toroidal grid.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// the word's result has been issued, and the result appears on the out_ ports
// for one cycle with out_valid, which cannot be held off. A cell write or read
// reads the row from the grid memory, then writes it back or picks the bit.
// An advance sweeps H rows, H being grid_height clamped to 3..MAX_ROWS; the
// grid memory has one read port, and after the window fill (ST_DISPATCH,
// ST_ADV_PRE1, ST_ADV_PRE2) the sweep writes one new row per cycle. Cells
// outside the configured rectangle are left untouched. The grid is dead after
// reset with no clearing pass; cfg_ready is low while busy is high, so
// configuration is written between words only.
// ----------------------------------------------------------------------------
`default_nettype none

module toroidal_life_generation_top
  import tlg_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ACT_W-1:0]     in_action,
  input  wire logic [COORD_W-1:0]   in_col,
  input  wire logic [COORD_W-1:0]   in_row,
  input  wire logic                 in_cell_value,
  output logic                      out_valid,
  output logic                      out_read_value,
  output logic                      out_status,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  tlg_cmd_t  cmd;
  tlg_stat_t stat;

  assign cfg_ready = !busy;

  tlg_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tlg_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

`default_nettype wire

@@ sim/life_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_checker
// Watches the command, result and register channels of the Life engine. It
// keeps its own copy of the grid and the grid size, works out the answer that
// each accepted word must bring, and compares the answers in order.
// ----------------------------------------------------------------------------
module life_checker
  import tlg_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [COORD_W-1:0]   in_col,
  input  logic [COORD_W-1:0]   in_row,
  input  logic                 in_cell_value,
  input  logic                 out_valid,
  input  logic                 out_read_value,
  input  logic                 out_status,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct packed {
    logic read_value;
    logic status;
  } answer_t;

  logic [MAX_COLS-1:0] life_grid [MAX_ROWS];
  logic [CFG_W-1:0]    width_reg;
  logic [CFG_W-1:0]    height_reg;
  answer_t             answers_due [$];
  answer_t             due;

  function automatic int span(input logic [CFG_W-1:0] size_val, input int limit);
    if (size_val < GRID_SIZE_MIN) return GRID_SIZE_MIN;
    if (size_val > limit) return limit;
    return int'(size_val);
  endfunction

  function automatic void evolve(input int w, input int h);
    logic [MAX_COLS-1:0] fresh [MAX_ROWS];
    int r, c, up, dn, lf, rt, n;
    for (r = 0; r < h; r++) begin
      up = (r == 0) ? h - 1 : r - 1;
      dn = (r + 1 == h) ? 0 : r + 1;
      for (c = 0; c < w; c++) begin
        lf = (c == 0) ? w - 1 : c - 1;
        rt = (c + 1 == w) ? 0 : c + 1;
        n = 0;
        n += life_grid[up][lf];
        n += life_grid[up][c];
        n += life_grid[up][rt];
        n += life_grid[r][lf];
        n += life_grid[r][rt];
        n += life_grid[dn][lf];
        n += life_grid[dn][c];
        n += life_grid[dn][rt];
        fresh[r][c] = (n == 3) || (n == 2 && life_grid[r][c]);
      end
    end
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++)
        life_grid[r][c] = fresh[r][c];
  endfunction

  function automatic answer_t predict_answer(input logic [ACT_W-1:0] act,
                                             input int col, input int row,
                                             input logic val);
    answer_t ans;
    int w, h;
    w   = span(width_reg, MAX_COLS);
    h   = span(height_reg, MAX_ROWS);
    ans = '0;
    if (act == ACT_WRITE || act == ACT_READ) begin
      if (col >= w || row >= h) ans.status = 1'b1;
      else if (act == ACT_WRITE) life_grid[row][col] = val;
      else ans.read_value = life_grid[row][col];
    end else if (act == ACT_ADVANCE) begin
      evolve(w, h);
    end else begin
      ans.status = 1'b1;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_ROWS; r++) life_grid[r] = '0;
      width_reg  = GRID_SIZE_RESET;
      height_reg = GRID_SIZE_RESET;
      answers_due.delete();
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected word: read_value=%0b status=%0b",
                   $time, out_read_value, out_status);
          fail_count <= fail_count + 1;
        end else begin
          due = answers_due.pop_front();
          if (out_read_value !== due.read_value || out_status !== due.status) begin
            $display("%0t: mismatch: expected read_value=%0b status=%0b, got read_value=%0b status=%0b",
                     $time, due.read_value, due.status, out_read_value, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDTH: begin
            width_reg = cfg_data;
          end
          REG_GRID_HEIGHT: begin
            height_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (start && !busy)
        answers_due.push_back(predict_answer(in_action, int'(in_col), int'(in_row),
                                             in_cell_value));
    end
    pending_count <= answers_due.size();
  end

endmodule

@@ sim/toroidal_life_generation_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_generation_top_tb
// Regression for the toroidal Life engine: directed wrap-around and corner
// cases, then phases that resize the grid, seed it, step it a few generations
// and read it back, with random noise words and random idle bursts.
// ----------------------------------------------------------------------------
module toroidal_life_generation_top_tb;
  import tlg_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int WORD_TARGET  = 1700;
  localparam int CALM_FROM    = 1450;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [ACT_W-1:0]     in_action;
  logic [COORD_W-1:0]   in_col;
  logic [COORD_W-1:0]   in_row;
  logic                 in_cell_value;
  logic                 out_valid;
  logic                 out_read_value;
  logic                 out_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending_count;
  int stall_cycles;
  int words_sent;
  int span_w;
  int span_h;
  bit calm;
  bit gappy;

  toroidal_life_generation_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  life_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input int col, input int row,
                           input logic val);
    start         <= 1'b1;
    in_action     <= act;
    in_col        <= COORD_W'(col);
    in_row        <= COORD_W'(row);
    in_cell_value <= val;
    do @(negedge clk); while (busy);
    @(posedge clk);
    words_sent++;
    calm = words_sent >= CALM_FROM;
    if (!calm && gappy && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_noise();
    send_word(ACT_W'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
              1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    if (!calm && $urandom_range(0, 1) == 0) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  function automatic int clamp_size(input logic [CFG_W-1:0] size_val);
    if (size_val < GRID_SIZE_MIN) return GRID_SIZE_MIN;
    if (size_val > 64) return 64;
    return int'(size_val);
  endfunction

  // drain the engine, then resize
  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0 || busy);
    @(posedge clk);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    cfg_valid <= 1'b0;
    span_w = clamp_size(w);
    span_h = clamp_size(h);
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return CFG_W'($urandom_range(0, 3));
    if (pick == 1) return CFG_W'($urandom_range(64, 127));
    if (pick == 2) return CFG_W'($urandom_range(13, 63));
    return CFG_W'($urandom_range(3, 12));
  endfunction

  task automatic run_phase();
    int steps, dens, org_c, org_r, c, r;
    steps = $urandom_range(1, 4);
    dens  = $urandom_range(15, 60);
    gappy = $urandom_range(0, 2) != 0;
    if (span_w * span_h <= 144) begin
      for (r = 0; r < span_h; r++)
        for (c = 0; c < span_w; c++) begin
          if ($urandom_range(0, 11) == 0) send_noise();
          send_word(ACT_WRITE, c, r, $urandom_range(0, 99) < dens);
        end
      repeat (steps)
        send_word(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      for (r = 0; r < span_h; r++)
        for (c = 0; c < span_w; c++) begin
          if ($urandom_range(0, 11) == 0) send_noise();
          send_word(ACT_READ, c, r, 1'($urandom_range(0, 1)));
        end
    end else begin
      // seed a patch that may straddle the wrap edges
      org_c = $urandom_range(0, span_w - 1);
      org_r = $urandom_range(0, span_h - 1);
      repeat (30)
        send_word(ACT_WRITE, (org_c + $urandom_range(0, 7)) % span_w,
                  (org_r + $urandom_range(0, 7)) % span_h, $urandom_range(0, 99) < dens);
      repeat (steps)
        send_word(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      repeat (30) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        send_word(ACT_READ, (org_c + $urandom_range(0, 9)) % span_w,
                  (org_r + $urandom_range(0, 9)) % span_h, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_action     <= ACT_WRITE;
    in_col        <= '0;
    in_row        <= '0;
    in_cell_value <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_GRID_WIDTH;
    cfg_data      <= '0;
    words_sent = 0;
    calm       = 1'b0;
    gappy      = 1'b0;
    span_w     = 64;
    span_h     = 64;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // blinker across the column wrap, lone corner cell
    send_word(ACT_WRITE, 0, 0, 1'b1);
    send_word(ACT_WRITE, 63, 0, 1'b1);
    send_word(ACT_WRITE, 1, 0, 1'b1);
    send_word(ACT_WRITE, 63, 63, 1'b1);
    send_word(ACT_READ, 0, 0, 1'b0);
    send_word(ACT_READ, 63, 63, 1'b0);
    send_word(ACT_ADVANCE, 0, 0, 1'b0);
    send_word(ACT_READ, 0, 63, 1'b0);
    send_word(ACT_READ, 0, 1, 1'b0);
    send_word(ACT_READ, 63, 0, 1'b0);
    send_word(ACT_READ, 63, 63, 1'b0);
    send_word(ACT_ADVANCE, 63, 63, 1'b1);
    send_word(ACT_READ, 63, 0, 1'b1);
    send_word(ACT_UNUSED, 63, 63, 1'b1);
    send_word(ACT_WRITE, 0, 0, 1'b0);
    send_word(ACT_READ, 0, 0, 1'b0);
    send_word(ACT_READ, 62, 62, 1'b1);

    // smallest torus: every cell neighbours all others
    configure(CFG_W'(0), CFG_W'(1));
    send_word(ACT_READ, 3, 0, 1'b0);
    send_word(ACT_WRITE, 0, 3, 1'b1);
    send_word(ACT_WRITE, 2, 2, 1'b1);
    send_word(ACT_WRITE, 0, 0, 1'b1);
    send_word(ACT_WRITE, 1, 1, 1'b1);
    send_word(ACT_ADVANCE, 0, 0, 1'b0);
    send_word(ACT_READ, 0, 1, 1'b0);

    configure(CFG_W'(127), CFG_W'(2));
    run_phase();
    while (words_sent < WORD_TARGET) begin
      configure(pick_size(), pick_size());
      run_phase();
    end

    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
